### src/pulse_period_speed_meter_core_macros.svh
// Assertion macros for the pulse period speed meter core.
`ifndef PULSE_PERIOD_SPEED_METER_CORE_MACROS_SVH
`define PULSE_PERIOD_SPEED_METER_CORE_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define PPSM_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define PPSM_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PPSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/ppsm_pkg.sv
// Shared constants and types of the pulse period speed meter.
package ppsm_pkg;

	// Field and register widths.
	localparam int TIME_W    = 32;
	localparam int SPEED_W   = 32;
	localparam int PER_W     = 16;
	localparam int MAG_W     = 8;
	localparam int THR_W     = 31;
	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 2;
	localparam int PHASE_W   = 10;

	// Check interval in ticks and fixed-point scaling.
	localparam int CHECK_PERIOD = 1000;
	localparam int SCALE        = 1000;
	localparam int SCALE_W      = 10;
	localparam int FRAC_W       = 16;
	localparam int MUL_W        = PER_W + SCALE_W;
	localparam int NUM_W        = MUL_W + FRAC_W;
	localparam int NUM_HI_W     = NUM_W - SPEED_W;

	// Shared divider sizing.
	localparam int DVD_W     = SPEED_W;
	localparam int DIV_CNT_W = $clog2(DVD_W + 1);

	// Reset values.
	localparam logic [PER_W-1:0]  PERIMETER_RST = PER_W'(2100);
	localparam logic [MAG_W-1:0]  MAGNET_RST    = MAG_W'(1);
	localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(3000000);
	localparam logic [TIME_W-1:0] LATEST_RST    = TIME_W'(3000000);
	localparam logic [SPEED_W-1:0] SPEED_SAT    = '1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PERIMETER = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MAGNETS   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(2);

	// Request to the shared divider.
	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] steps;
		logic [TIME_W-1:0]    rem;
		logic [DVD_W-1:0]     dvd;
		logic [TIME_W-1:0]    dsr;
	} div_req_t;

	// Status of the shared divider.
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quot;
	} div_rsp_t;

endpackage

### src/ppsm_div.sv
// Shared restoring divider: one quotient bit per clock cycle.
module ppsm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ppsm_pkg::div_req_t req,
	output ppsm_pkg::div_rsp_t rsp
);
	import ppsm_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TIME_W-1:0]    rem_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [TIME_W-1:0]    dsr_q;
	logic [TIME_W:0]      rem_sh;
	logic [TIME_W:0]      diff;
	logic                 ge;
	logic [TIME_W-1:0]    rem_next;

	// One shift-and-subtract step.
	always_comb begin
		rem_sh   = {rem_q, dvd_q[DVD_W-1]};
		ge       = rem_sh >= {1'b0, dsr_q};
		diff     = rem_sh - {1'b0, dsr_q};
		rem_next = ge ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= req.steps;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Remainder, dividend and divisor; quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem;
			dvd_q <= req.dvd;
			dsr_q <= req.dsr;
		end else if (cnt_q != '0) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign rsp.busy = cnt_q != '0;
	assign rsp.done = cnt_q == DIV_CNT_W'(1);
	assign rsp.quot = dvd_q;

endmodule

### src/pulse_period_speed_meter_core.sv
// Top level of the pulse period speed meter: tick sequencer, check logic and outputs.
// A tick without a check, or a check that ends in a stop or a zero-interval or zero-magnet
// saturation, loads the output register when it is free and else waits in the done state.
// A check that computes a speed runs the accept, a divider run for the 16-bit pulse length,
// one multiply, one overflow compare, a divider run for the 32-bit speed, one store, one load.
// An overflowing quotient ends after the compare; reset clears all counters.
`include "pulse_period_speed_meter_core_macros.svh"

module pulse_period_speed_meter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              edge_seen,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ppsm_pkg::SPEED_W-1:0]      speed_q16,
	output logic                              checked,
	input  logic                              cfg_we,
	input  logic [ppsm_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [ppsm_pkg::CFG_W-1:0]        cfg_data
);
	import ppsm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV1,
		S_MUL,
		S_CHK,
		S_DIV2,
		S_STORE,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [PER_W-1:0]   per_q;
	logic [MAG_W-1:0]   mag_q;
	logic [THR_W-1:0]   thr_q;
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  last_q;
	logic [TIME_W-1:0]  latest_q;
	logic               pend_q;
	logic [PHASE_W-1:0] phase_q;
	logic [SPEED_W-1:0] speed_val_q;
	logic               chk_res_q;
	logic [TIME_W-1:0]  dt_q;
	logic [MUL_W-1:0]   mul_q;
	logic               out_valid_q;
	logic [SPEED_W-1:0] speed_out_q;
	logic               chk_out_q;

	logic [PHASE_W-1:0]  phase_inc;
	logic                due;
	logic [TIME_W-1:0]   latest_n;
	logic                pend_n;
	logic [TIME_W-1:0]   elapsed;
	logic                stopped;
	logic [TIME_W-1:0]   dt_n;
	logic                quick_sat;
	logic                need_div;
	logic [SPEED_W-1:0]  speed_n;
	logic                accept;
	logic                out_free;
	logic [MUL_W-1:0]    mul_n;
	logic [NUM_W-1:0]    num;
	logic [NUM_HI_W-1:0] num_hi;
	logic                ovf;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	ppsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Tick bookkeeping and the check decision for the beat at the input.
	always_comb begin
		accept    = in_valid && !in_stall;
		out_free  = !out_valid_q || !out_stall;
		phase_inc = phase_q + 1'b1;
		due       = phase_inc >= PHASE_W'(CHECK_PERIOD);
		latest_n  = edge_seen ? now_q : latest_q;
		pend_n    = edge_seen || pend_q;
		elapsed   = now_q - last_q;
		stopped   = elapsed > TIME_W'(thr_q);
		dt_n      = latest_n - last_q;
		quick_sat = (mag_q == '0) || (dt_n == '0);
		need_div  = due && !stopped && pend_n && !quick_sat;
		if (due && stopped) begin
			speed_n = '0;
		end else if (due && pend_n) begin
			speed_n = SPEED_SAT;
		end else begin
			speed_n = speed_val_q;
		end
	end

	// Scaled pulse length and the split of the Q16.16 numerator.
	always_comb begin
		mul_n  = MUL_W'(div_rsp.quot[PER_W-1:0]) * MUL_W'(SCALE);
		num    = {mul_q, FRAC_W'(0)};
		num_hi = num[NUM_W-1:SPEED_W];
		ovf    = TIME_W'(num_hi) >= dt_q;
	end

	// Divider requests: pulse length first, then the speed quotient.
	always_comb begin
		div_req.start = 1'b0;
		div_req.steps = DIV_CNT_W'(SPEED_W);
		div_req.rem   = TIME_W'(num_hi);
		div_req.dvd   = num[SPEED_W-1:0];
		div_req.dsr   = dt_q;
		case (state_q)
			S_IDLE: begin
				if (accept && need_div) begin
					div_req.start = 1'b1;
					div_req.steps = DIV_CNT_W'(PER_W);
					div_req.rem   = '0;
					div_req.dvd   = {per_q, (DVD_W - PER_W)'(0)};
					div_req.dsr   = TIME_W'(mag_q);
				end
			end
			S_CHK: begin
				div_req.start = !ovf;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_q <= PERIMETER_RST;
			mag_q <= MAGNET_RST;
			thr_q <= THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_PERIMETER: per_q <= cfg_data[PER_W-1:0];
				CFG_MAGNETS:   mag_q <= cfg_data[MAG_W-1:0];
				CFG_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer, timing state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			now_q       <= '0;
			last_q      <= '0;
			latest_q    <= LATEST_RST;
			pend_q      <= 1'b0;
			phase_q     <= '0;
			speed_val_q <= '0;
			chk_res_q   <= 1'b0;
			dt_q        <= '0;
			mul_q       <= '0;
			out_valid_q <= 1'b0;
			speed_out_q <= '0;
			chk_out_q   <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						phase_q     <= due ? '0 : phase_inc;
						now_q       <= now_q + 1'b1;
						latest_q    <= latest_n;
						pend_q      <= pend_n;
						dt_q        <= dt_n;
						speed_val_q <= speed_n;
						chk_res_q   <= due;
						// A due check consumes a pending edge as the new reference.
						if (due && pend_n) begin
							last_q <= latest_n;
							pend_q <= 1'b0;
						end
						if (need_div) begin
							state_q <= S_DIV1;
						end else if (out_free) begin
							out_valid_q <= 1'b1;
							speed_out_q <= speed_n;
							chk_out_q   <= due;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DIV1: begin
					if (div_rsp.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					mul_q   <= mul_n;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (ovf) begin
						speed_val_q <= SPEED_SAT;
						state_q     <= S_DONE;
					end else begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_rsp.done) begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					speed_val_q <= div_rsp.quot;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						speed_out_q <= speed_val_q;
						chk_out_q   <= chk_res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign speed_q16 = speed_out_q;
	assign checked   = chk_out_q;

	// Design checks.
	`PPSM_ASSERT_IMPLY(a_div_busy_stalls, div_rsp.busy, in_stall, "input taken while divider runs")
	`PPSM_ASSERT_IMPLY(a_div_start_free, div_req.start, !div_rsp.busy, "divider restarted while busy")
	`PPSM_ASSERT_ALWAYS(a_phase_range, phase_q < PHASE_W'(CHECK_PERIOD), "check phase out of range")
	`PPSM_ASSERT_NEXT(a_ovf_sat, (state_q == S_CHK) && ovf, speed_val_q == SPEED_SAT, "overflow not saturated")

endmodule

### sim/pulse_period_speed_meter_core_tb.sv
// Self-checking testbench for the pulse period speed meter core with a speed predictor.
`timescale 1ns / 1ps

module pulse_period_speed_meter_core_tb;
	import ppsm_pkg::*;

	// Cycles to let pass after the last result before a register write or the end.
	localparam int SETTLE_CYCLES = 64;

	// One output beat: the held speed and the check flag.
	typedef struct {
		logic [SPEED_W-1:0] speed;
		logic               checked;
	} meter_beat_t;

	// Tracks the meter state tick by tick and compares output beats in order.
	class speed_tracker;
		logic [PER_W-1:0]   perimeter;
		logic [MAG_W-1:0]   magnets;
		logic [THR_W-1:0]   threshold;
		logic [TIME_W-1:0]  now_us;
		logic [TIME_W-1:0]  trigger_us;
		logic [TIME_W-1:0]  edge_us;
		logic               pulse_pending;
		int                 phase;
		logic [SPEED_W-1:0] speed;
		meter_beat_t        expected[$];
		int                 mismatches;
		int                 beats_seen;

		function new();
			perimeter     = PERIMETER_RST;
			magnets       = MAGNET_RST;
			threshold     = THRESHOLD_RST;
			now_us        = '0;
			trigger_us    = '0;
			edge_us       = LATEST_RST;
			pulse_pending = 1'b0;
			phase         = 0;
			speed         = '0;
			mismatches    = 0;
			beats_seen    = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			case (idx)
				CFG_PERIMETER: perimeter = value[PER_W-1:0];
				CFG_MAGNETS:   magnets   = value[MAG_W-1:0];
				CFG_THRESHOLD: threshold = value[THR_W-1:0];
				default: ;
			endcase
		endfunction

		// Speed in Q16.16 m/s for a pulse interval, saturated on zero divisors and overflow.
		function logic [SPEED_W-1:0] speed_for(logic [TIME_W-1:0] dt);
			logic [63:0] per_pulse;
			logic [63:0] num;
			logic [63:0] quot;
			if (magnets == '0 || dt == '0)
				return SPEED_SAT;
			per_pulse = 64'(perimeter) / 64'(magnets);
			num = (per_pulse * 64'd1000) << FRAC_W;
			quot = num / 64'(dt);
			if (quot > 64'(SPEED_SAT))
				return SPEED_SAT;
			return quot[SPEED_W-1:0];
		endfunction

		// An accepted input beat: capture the edge, run the check when due, advance time.
		function void note_tick(logic pulse);
			meter_beat_t       beat;
			logic [TIME_W-1:0] elapsed;
			if (pulse) begin
				edge_us = now_us;
				pulse_pending = 1'b1;
			end
			beat.checked = 1'b0;
			phase++;
			if (phase >= CHECK_PERIOD) begin
				phase = 0;
				beat.checked = 1'b1;
				elapsed = now_us - trigger_us;
				if (elapsed > TIME_W'(threshold)) begin
					// Wheel stopped; a late edge only becomes the new reference.
					speed = '0;
					if (pulse_pending) begin
						pulse_pending = 1'b0;
						trigger_us = edge_us;
					end
				end else if (pulse_pending) begin
					speed = speed_for(edge_us - trigger_us);
					trigger_us = edge_us;
					pulse_pending = 1'b0;
				end
			end
			now_us++;
			beat.speed = speed;
			expected.push_back(beat);
		endfunction

		// An accepted output beat against the oldest expectation.
		function void check_result(logic [SPEED_W-1:0] got_speed, logic got_checked);
			meter_beat_t want;
			beats_seen++;
			if (expected.size() == 0) begin
				$error("unexpected output beat: speed_q16=%h checked=%b", got_speed, got_checked);
				mismatches++;
				return;
			end
			want = expected.pop_front();
			if (got_speed !== want.speed) begin
				$error("speed_q16: expected %h, actual %h", want.speed, got_speed);
				mismatches++;
			end
			if (got_checked !== want.checked) begin
				$error("checked: expected %b, actual %b", want.checked, got_checked);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic                 edge_seen = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [SPEED_W-1:0]   speed_q16;
	logic                 checked;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx   = CFG_PERIMETER;
	logic [CFG_W-1:0]     cfg_data  = '0;

	speed_tracker trk = new();
	bit           no_idle   = 1'b0;
	int           hold_left = 0;
	int           next_hold = 400;

	pulse_period_speed_meter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.edge_seen (edge_seen),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.speed_q16 (speed_q16),
		.checked   (checked),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Input beats feed the predictor before output beats are checked at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				trk.note_tick(edge_seen);
			if (out_valid && !out_stall)
				trk.check_result(speed_q16, checked);
		end
	end

	// Receiver: random stalls, plus a long hold now and then so the core backs up.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall = 1'b0;
		end else if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else if (trk.beats_seen >= next_hold) begin
			out_stall = 1'b1;
			hold_left = 600;
			next_hold += 25000;
		end else begin
			out_stall = !no_idle && ($urandom_range(0, 99) < 26);
		end
	end

	// Offers one tick, with random gaps before it, and holds it until accepted.
	task automatic send_tick(input logic pulse);
		while (!no_idle && $urandom_range(0, 99) < 26) begin
			in_valid = 1'b0;
			edge_seen = $urandom_range(0, 1);
			@(negedge clk);
		end
		in_valid = 1'b1;
		edge_seen = pulse;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// A run of ticks with an edge in each at the given rate per ten thousand.
	task automatic run_ticks(input int n, input int rate);
		repeat (n)
			send_tick($urandom_range(0, 9999) < rate);
	endtask

	// Waits until every expected beat is back and the core has gone quiet.
	task automatic settle();
		in_valid = 1'b0;
		while (trk.expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		trk.set_reg(idx, value);
	endtask

	task automatic set_config(input logic [PER_W-1:0] per, input logic [MAG_W-1:0] mag,
			input logic [THR_W-1:0] thr);
		settle();
		write_reg(CFG_PERIMETER, CFG_W'(per));
		write_reg(CFG_MAGNETS, CFG_W'(mag));
		write_reg(CFG_THRESHOLD, CFG_W'(thr));
	endtask

	// Stimulus: one full check period with a speed update, then gapless and random traffic.
	initial begin
		logic [PER_W-1:0] per;
		logic [MAG_W-1:0] mag;

		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Random wheel and magnet count for the periodic check of this run.
		per = PER_W'($urandom_range(1, 65535));
		mag = MAG_W'($urandom_range(1, 255));
		set_config(per, mag, THRESHOLD_RST);

		// Edges on the first tick and half way; the check on tick 1000 computes a speed.
		run_ticks(1, 10000);
		run_ticks(499, 0);
		run_ticks(1, 10000);
		run_ticks(499, 0);

		// A stretch with no gaps and no stalls at all, then random traffic.
		no_idle = 1'b1;
		run_ticks(300, 300);
		no_idle = 1'b0;
		run_ticks(450, 300);

		settle();
		if (trk.mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Hard limit on the run time.
	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/ppsm_pkg.sv
src/ppsm_div.sv
src/pulse_period_speed_meter_core.sv
sim/pulse_period_speed_meter_core_tb.sv
